/* rtl/adcrb_pkg.sv */
// shared types, register map constants and helpers for the adc register block
`default_nettype none

package adcrb_pkg;

  localparam int NumChannelsDef = 5;
  localparam int FifoDepthDef   = 4;
  localparam int TempChannelDef = 4;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_SAMPLE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ALIAS_PLAIN = 2'd0,
    ALIAS_XOR   = 2'd1,
    ALIAS_SET   = 2'd2,
    ALIAS_CLR   = 2'd3
  } alias_e;

  localparam logic [11:0] OFF_CS     = 12'h000;
  localparam logic [11:0] OFF_RESULT = 12'h004;
  localparam logic [11:0] OFF_FCS    = 12'h008;
  localparam logic [11:0] OFF_FIFO   = 12'h00C;
  localparam logic [11:0] OFF_DIV    = 12'h010;
  localparam logic [11:0] OFF_INTR   = 12'h014;
  localparam logic [11:0] OFF_INTE   = 12'h018;
  localparam logic [11:0] OFF_INTF   = 12'h01C;
  localparam logic [11:0] OFF_INTS   = 12'h020;

  localparam logic [31:0] CS_WRITABLE  = 32'h001F_700F;
  localparam logic [31:0] CS_READY     = 32'h0000_0100;
  localparam logic [31:0] FCS_WRITABLE = 32'h0F00_000F;

  localparam int CsStartOnceBit = 2;
  localparam int CsAinselLsb    = 12;
  localparam int CsAinselMsb    = 14;
  localparam int CsRrobinLsb    = 16;
  localparam int CsRrobinMsb    = 20;
  localparam int FcsEnBit       = 0;
  localparam int FcsShiftBit    = 1;
  localparam int FcsEmptyBit    = 8;
  localparam int FcsFullBit     = 9;
  localparam int FcsUnderBit    = 10;
  localparam int FcsOverBit     = 11;
  localparam int FcsLevelLsb    = 16;
  localparam int FcsLevelMsb    = 19;
  localparam int FcsThreshLsb   = 24;
  localparam int FcsThreshMsb   = 27;

  localparam logic [11:0] TEMP_RESET = 12'h36C;

  typedef struct packed {
    logic        push;
    logic        pop;
    logic [11:0] data;
  } fifo_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
  } result_t;

  function automatic logic [31:0] apply_alias(input logic [31:0] old_val,
                                              input logic [31:0] wr_val,
                                              input alias_e      al);
    logic [31:0] res;
    case (al)
      ALIAS_XOR: res = old_val ^ wr_val;
      ALIAS_SET: res = old_val | wr_val;
      ALIAS_CLR: res = old_val & ~wr_val;
      default:   res = wr_val;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/adcrb_fifo.sv */
// sample fifo: small register array with read and write pointers and fill level
`default_nettype none

module adcrb_fifo import adcrb_pkg::*; #(
  parameter int FIFO_DEPTH = FifoDepthDef,
  localparam int LvlW = $clog2(FIFO_DEPTH + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire fifo_req_t       req_i,
  output logic [11:0]          head_o,
  output logic [LvlW-1:0]      level_o
);

  localparam int PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(FIFO_DEPTH - 1);

  logic [11:0]     store_q [FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [LvlW-1:0] level_q, level_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (req_i.push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      level_d  = level_q + 1'b1;
    end else if (req_i.pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      level_d  = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      store_q[wr_ptr_q] <= req_i.data;
    end
  end

  assign head_o  = store_q[rd_ptr_q];
  assign level_o = level_q;

endmodule

`default_nettype wire

/* rtl/adcrb_rr.sv */
// round-robin pick of the next channel after the current one
`default_nettype none

module adcrb_rr import adcrb_pkg::*; #(
  parameter int NUM_CHANNELS = NumChannelsDef
) (
  input  wire logic [2:0] sel_i,
  input  wire logic [4:0] mask_i,
  output logic [2:0]      next_sel_o
);

  localparam logic [3:0] NCh      = 4'(NUM_CHANNELS);
  localparam int         ModSteps = 8 / NUM_CHANNELS;

  logic [3:0] base;
  logic [3:0] cand;
  logic       found;

  always_comb begin
    base = {1'b0, sel_i} + 4'd1;
    for (int k = 0; k < ModSteps; k++) begin
      if (base >= NCh) begin
        base = base - NCh;
      end
    end
    next_sel_o = sel_i;
    found      = 1'b0;
    cand       = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      cand = base + 4'(i);
      if (cand >= NCh) begin
        cand = cand - NCh;
      end
      if (!found && mask_i[cand[2:0]]) begin
        next_sel_o = cand[2:0];
        found      = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/adcrb_core.sv */
// register file, bus decode and conversion logic of the adc register block
`default_nettype none

module adcrb_core import adcrb_pkg::*; #(
  parameter int NUM_CHANNELS = NumChannelsDef,
  parameter int FIFO_DEPTH   = FifoDepthDef,
  parameter int TEMP_CHANNEL = TempChannelDef,
  localparam int LvlW = $clog2(FIFO_DEPTH + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fire_i,
  input  wire logic [1:0]      kind_i,
  input  wire logic [13:0]     address_i,
  input  wire logic [31:0]     write_data_i,
  input  wire logic [2:0]      channel_i,
  input  wire logic [11:0]     sample_i,
  input  wire logic [11:0]     fifo_head_i,
  input  wire logic [LvlW-1:0] fifo_level_i,
  output fifo_req_t            fifo_req_o,
  output result_t              result_o
);

  localparam int              ChW   = $clog2(NUM_CHANNELS);
  localparam logic [2:0]      NCh   = 3'(NUM_CHANNELS);
  localparam logic [LvlW-1:0] LvlFull = LvlW'(FIFO_DEPTH);

  logic [20:0] cs_q, cs_d;
  logic [27:0] fcs_q, fcs_d;
  logic [31:0] div_q, div_d;
  logic [31:0] inte_q, inte_d;
  logic        intr_q, intr_d;
  logic        under_q, under_d;
  logic        over_q, over_d;
  logic [11:0] samples_q [NUM_CHANNELS];

  logic [11:0]     off;
  alias_e          al;
  logic [31:0]     cs_wr;
  logic [2:0]      rd_sel;
  logic [11:0]     samp_rd;
  logic [2:0]      rr_next;
  logic [11:0]     conv_val;
  logic [LvlW-1:0] level_after;
  logic [3:0]      thresh;
  logic [31:0]     fcs_rd;
  fifo_req_t       req;
  result_t         res;

  assign off    = address_i[11:0];
  assign al     = alias_e'(address_i[13:12]);
  assign cs_wr  = apply_alias({11'b0, cs_q}, write_data_i, al) & CS_WRITABLE;
  assign thresh = fcs_q[FcsThreshMsb:FcsThreshLsb];

  // conversions take the channel selected by the new cs value
  assign rd_sel  = (kind_e'(kind_i) == KIND_WRITE) ? cs_wr[CsAinselMsb:CsAinselLsb]
                                                   : cs_q[CsAinselMsb:CsAinselLsb];
  assign samp_rd = (rd_sel < NCh) ? samples_q[rd_sel[ChW-1:0]] : '0;

  adcrb_rr #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_rr (
    .sel_i     (cs_wr[CsAinselMsb:CsAinselLsb]),
    .mask_i    (cs_wr[CsRrobinMsb:CsRrobinLsb]),
    .next_sel_o(rr_next)
  );

  always_comb begin
    fcs_rd                          = {4'b0, fcs_q};
    fcs_rd[FcsEmptyBit]             = (fifo_level_i == '0);
    fcs_rd[FcsFullBit]              = (fifo_level_i == LvlFull);
    fcs_rd[FcsUnderBit]             = under_q;
    fcs_rd[FcsOverBit]              = over_q;
    fcs_rd[FcsLevelMsb:FcsLevelLsb] = 4'(fifo_level_i);
  end

  always_comb begin
    cs_d        = cs_q;
    fcs_d       = fcs_q;
    div_d       = div_q;
    inte_d      = inte_q;
    intr_d      = intr_q;
    under_d     = under_q;
    over_d      = over_q;
    req         = '0;
    res         = '0;
    level_after = fifo_level_i;
    conv_val    = samp_rd;
    case (kind_e'(kind_i))
      KIND_READ: begin
        case (off)
          OFF_CS:     res.read_data = {11'b0, cs_q} | CS_READY;
          OFF_RESULT: res.read_data = {20'b0, samp_rd};
          OFF_FCS:    res.read_data = fcs_rd;
          OFF_FIFO: begin
            if (fifo_level_i == '0) begin
              under_d = 1'b1;
            end else begin
              req.pop       = 1'b1;
              res.read_data = {20'b0, fifo_head_i};
            end
          end
          OFF_DIV:    res.read_data = div_q;
          OFF_INTR:   res.read_data = {31'b0, intr_q};
          OFF_INTE:   res.read_data = inte_q;
          OFF_INTF:   res.read_data = '0;
          OFF_INTS:   res.read_data = {31'b0, intr_q & inte_q[0]};
          default:    res.read_data = '0;
        endcase
      end
      KIND_WRITE: begin
        case (off)
          OFF_CS: begin
            cs_d = cs_wr[20:0];
            if (cs_wr[CsStartOnceBit]) begin
              if (fcs_q[FcsEnBit]) begin
                if (fcs_q[FcsShiftBit]) begin
                  conv_val = {4'b0, samp_rd[11:4]};
                end
                if (fifo_level_i == LvlFull) begin
                  over_d = 1'b1;
                end else begin
                  req.push    = 1'b1;
                  req.data    = conv_val;
                  level_after = fifo_level_i + 1'b1;
                end
              end
              if (thresh != '0 && 4'(level_after) >= thresh) begin
                intr_d  = 1'b1;
                res.irq = inte_q[0];
              end
              cs_d[CsStartOnceBit]          = 1'b0;
              cs_d[CsAinselMsb:CsAinselLsb] = rr_next;
            end
          end
          OFF_FCS: begin
            fcs_d = 28'(apply_alias({4'b0, fcs_q}, write_data_i, al) & FCS_WRITABLE);
            if (write_data_i[FcsUnderBit]) begin
              under_d = 1'b0;
            end
            if (write_data_i[FcsOverBit]) begin
              over_d = 1'b0;
            end
          end
          OFF_DIV:  div_d  = apply_alias(div_q, write_data_i, al);
          OFF_INTE: inte_d = apply_alias(inte_q, write_data_i, al);
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q    <= '0;
      fcs_q   <= '0;
      div_q   <= '0;
      inte_q  <= '0;
      intr_q  <= 1'b0;
      under_q <= 1'b0;
      over_q  <= 1'b0;
    end else if (fire_i) begin
      cs_q    <= cs_d;
      fcs_q   <= fcs_d;
      div_q   <= div_d;
      inte_q  <= inte_d;
      intr_q  <= intr_d;
      under_q <= under_d;
      over_q  <= over_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        samples_q[i] <= (i == TEMP_CHANNEL) ? TEMP_RESET : '0;
      end
    end else if (fire_i && kind_e'(kind_i) == KIND_SAMPLE && channel_i < NCh) begin
      samples_q[channel_i[ChW-1:0]] <= sample_i;
    end
  end

  assign fifo_req_o = fire_i ? req : '0;
  assign result_o   = res;

endmodule

`default_nettype wire

/* rtl/adc_register_block_with_fifo.sv */
// top level of the adc register block: input register, core, fifo, output register
//
// Input channel: in_valid_i / in_stall_o with one bus read, bus write or
// analog sample setting per word (kind_i, address_i, write_data_i,
// channel_i, sample_i). Output channel: out_valid_o / out_stall_i, exactly
// one result word (read_data_o, fifo_irq_o) per input word, in order.
// A word is taken into the input register, decoded and applied to the
// register file and sample fifo as it leaves, and its result is captured
// in the output register, where out_valid_o then rises to offer it.
// Throughput is one word per cycle while the output is not stalled; the
// register update and fifo access of a word all happen in the cycle it
// moves from the input to the output register.
// When the receiver stalls, the result holds in the output register and
// one more word can wait in the input register; beyond that in_stall_o
// rises until the output is taken.
// Reset clears all control registers, the fifo pointers and flags and the
// channel samples (the temperature channel returns to its fixed value).
`default_nettype none

module adc_register_block_with_fifo import adcrb_pkg::*; #(
  parameter int NUM_CHANNELS = NumChannelsDef,
  parameter int FIFO_DEPTH   = FifoDepthDef,
  parameter int TEMP_CHANNEL = TempChannelDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [13:0] address_i,
  input  wire logic [31:0] write_data_i,
  input  wire logic [2:0]  channel_i,
  input  wire logic [11:0] sample_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      read_data_o,
  output logic             fifo_irq_o
);

  localparam int LvlW = $clog2(FIFO_DEPTH + 1);

  logic        in_valid_q;
  logic [1:0]  kind_q;
  logic [13:0] address_q;
  logic [31:0] write_data_q;
  logic [2:0]  channel_q;
  logic [11:0] sample_q;
  logic        out_valid_q;
  result_t     result_q;

  logic            advance;
  logic            accept;
  fifo_req_t       fifo_req;
  logic [11:0]     fifo_head;
  logic [LvlW-1:0] fifo_level;
  result_t         result_d;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q       <= kind_i;
      address_q    <= address_i;
      write_data_q <= write_data_i;
      channel_q    <= channel_i;
      sample_q     <= sample_i;
    end
  end

  adcrb_core #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .FIFO_DEPTH  (FIFO_DEPTH),
    .TEMP_CHANNEL(TEMP_CHANNEL)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .kind_i      (kind_q),
    .address_i   (address_q),
    .write_data_i(write_data_q),
    .channel_i   (channel_q),
    .sample_i    (sample_q),
    .fifo_head_i (fifo_head),
    .fifo_level_i(fifo_level),
    .fifo_req_o  (fifo_req),
    .result_o    (result_d)
  );

  adcrb_fifo #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fifo_req),
    .head_o (fifo_head),
    .level_o(fifo_level)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = result_q.read_data;
  assign fifo_irq_o  = result_q.irq;

endmodule

`default_nettype wire

/* rtl/adcrb_checker.sv */
// port-level checker for the adc register block and its bind
`default_nettype none

module adcrb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] read_data_o,
  input wire logic        fifo_irq_o
);

  // a held result does not change while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o) && $stable(fifo_irq_o))
    else $error("output word changed under stall");

  // input backs up only when the output side is stalled and full
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // interrupt pulses come only from writes, which return zero data
  a_irq_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fifo_irq_o |-> read_data_o == 32'h0)
    else $error("interrupt pulse with nonzero read data");

  // a free output stage never holds off the input
  a_no_stall_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output empty");

endmodule

bind adc_register_block_with_fifo adcrb_checker u_adcrb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .read_data_o(read_data_o),
  .fifo_irq_o (fifo_irq_o)
);

`default_nettype wire
